// ===== rtl/core/cfm_pkg.sv =====
// Package for the Curve25519 field multiplier: limb types and modulus constants.
// No dependencies.
`default_nettype none
package cfm_pkg;
    localparam int LIMB_W = 64;
    typedef logic [LIMB_W-1:0] t_limb;
    localparam logic [255:0] MODULUS_P = {64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                                          64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFED};
    localparam logic [5:0] FOLD_FACTOR = 6'd38;
endpackage
`default_nettype wire

// ===== rtl/core/curve25519_field_multiplier_top.sv =====
// Pipelined Curve25519 field multiplier, 4 x 64-bit limbs, modulus 2^255-19.
// Depends on cfm_pkg.
//
// Usage: present a and b limbs with i_valid; a word is taken at a clock edge
// where i_valid is high and o_stall is low. The reduced product appears on
// o_prod_limb* with o_valid and is taken when i_stall is low.
// Throughput: one word per cycle while i_stall does not hold the pipeline;
// the four 32x32 partial products of each 64x64 limb product are formed in
// one stage, so 64 multipliers of 32x32 bits set the area of the first stage.
// Stages: 32-bit partial products; 64x64 limb products; diagonal sums of
// limb products; 512-bit product; fold by 38; second fold of the carry;
// conditional subtraction of p.
// Reset clears all stage valid bits; payload registers are not reset.
// When the receiver stalls a valid output word, the whole pipeline holds and
// o_stall rises, so no word is lost or repeated; o_stall is i_stall gated
// by o_valid.
`default_nettype none
module curve25519_field_multiplier_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output      logic            o_stall,
    input  wire cfm_pkg::t_limb  i_a_limb0,
    input  wire cfm_pkg::t_limb  i_a_limb1,
    input  wire cfm_pkg::t_limb  i_a_limb2,
    input  wire cfm_pkg::t_limb  i_a_limb3,
    input  wire cfm_pkg::t_limb  i_b_limb0,
    input  wire cfm_pkg::t_limb  i_b_limb1,
    input  wire cfm_pkg::t_limb  i_b_limb2,
    input  wire cfm_pkg::t_limb  i_b_limb3,
    output      logic            o_valid,
    input  wire logic            i_stall,
    output      cfm_pkg::t_limb  o_prod_limb0,
    output      cfm_pkg::t_limb  o_prod_limb1,
    output      cfm_pkg::t_limb  o_prod_limb2,
    output      cfm_pkg::t_limb  o_prod_limb3
);
    import cfm_pkg::*;

    logic [6:0]   r_vld;
    logic         adv;
    logic [63:0]  a [4];
    logic [63:0]  b [4];
    // stage 1: 32x32 partial products per limb pair
    logic [63:0]  r_pp [4][4][4];
    // stage 2: 128-bit limb products
    logic [127:0] r_lp [4][4];
    // stage 3: sums of limb products on each diagonal i+j
    logic [129:0] r_diag [7];
    // stage 4: 512-bit product
    logic [511:0] r_wide;
    // stage 5: first fold, 263 bits
    logic [262:0] r_f1;
    // stage 6: second fold
    logic [255:0] r_f2;
    // stage 7: output
    logic [255:0] r_out;

    logic [129:0] n_diag [7];
    logic [511:0] n_wide;
    logic [262:0] n_f1;
    logic [255:0] n_f2;
    logic [256:0] diff;

    assign a = '{i_a_limb0, i_a_limb1, i_a_limb2, i_a_limb3};
    assign b = '{i_b_limb0, i_b_limb1, i_b_limb2, i_b_limb3};

    // the pipeline moves unless the output holds a word the receiver stalls
    assign adv     = !(r_vld[6] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            n_diag[k] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_diag[i + j] = n_diag[i + j] + {2'd0, r_lp[i][j]};
            end
        end
        n_wide = '0;
        for (int k = 0; k < 7; k++) begin
            n_wide = n_wide + ({382'd0, r_diag[k]} << (64 * k));
        end
        n_f1 = {7'd0, r_wide[255:0]} + 263'(r_wide[511:256] * 263'(FOLD_FACTOR));
        // carry out of the top limb is dropped
        n_f2 = r_f1[255:0] + 256'(r_f1[262:256] * 13'(FOLD_FACTOR));
        diff = {1'b0, r_f2} - {1'b0, MODULUS_P};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_pp[i][j][0] <= a[i][31:0]  * b[j][31:0];
                    r_pp[i][j][1] <= a[i][31:0]  * b[j][63:32];
                    r_pp[i][j][2] <= a[i][63:32] * b[j][31:0];
                    r_pp[i][j][3] <= a[i][63:32] * b[j][63:32];
                    r_lp[i][j] <= {64'd0, r_pp[i][j][0]}
                                + ({64'd0, r_pp[i][j][1]} << 32)
                                + ({64'd0, r_pp[i][j][2]} << 32)
                                + ({r_pp[i][j][3], 64'd0});
                end
            end
            for (int k = 0; k < 7; k++) begin
                r_diag[k] <= n_diag[k];
            end
            r_wide <= n_wide;
            r_f1   <= n_f1;
            r_f2   <= n_f2;
            // keep the subtraction only when it does not borrow
            r_out  <= diff[256] ? r_f2 : diff[255:0];
        end
    end

    assign o_valid      = r_vld[6];
    assign o_prod_limb0 = r_out[63:0];
    assign o_prod_limb1 = r_out[127:64];
    assign o_prod_limb2 = r_out[191:128];
    assign o_prod_limb3 = r_out[255:192];
endmodule
`default_nettype wire

// ===== rtl/core/cfm_checker.sv =====
// Port-level checker for the field multiplier, bound to the top level.
// Depends on curve25519_field_multiplier_top.
`default_nettype none
module cfm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [63:0] o_prod_limb3
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_prod_limb3))
        else $error("output word changed under stall");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_prod_limb3[63:62] != 2'b11)
        else $error("result above folded range");
endmodule

bind curve25519_field_multiplier_top cfm_checker u_cfm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_prod_limb3(o_prod_limb3)
);
`default_nettype wire
